FILE: hdl/string_hash_three_word_mix_unit_macros.svh
// Assertion macros used by the checker file of the string hash unit.
`ifndef STRING_HASH_THREE_WORD_MIX_UNIT_MACROS_SVH
`define STRING_HASH_THREE_WORD_MIX_UNIT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is held.
`define SHTW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shtw assertion failed");

// Concurrent assertion on the rising clock edge that also holds through reset.
`define SHTW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shtw reset assertion failed");

`endif

FILE: hdl/shtw_pkg.sv
// Package of types, constants and helper functions for the string hash unit.
`timescale 1ns / 1ps
package shtw_pkg;

    localparam int unsigned C_MIX_STEPS = 7;
    localparam int unsigned C_STAGES    = C_MIX_STEPS + 1;

    // The golden word and the extra seed are folded into one starting value of the length term.
    localparam logic [31:0] C_SEED_INIT = 32'(64'h9e3779b9 + 64'd3923095);

    localparam logic [3:0] C_FIFTH_POS = 4'd4;
    localparam logic [3:0] C_SPLIT_POS = 4'd5;
    localparam logic [3:0] C_J_POS     = 4'd8;
    localparam logic [3:0] C_BLOCK_END = 4'd11;

    localparam logic [4:0] C_MIX_ROT [C_MIX_STEPS] = '{
        5'd14, 5'd11, 5'd25, 5'd16, 5'd4, 5'd14, 5'd24
    };

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } t_words;

    typedef struct packed {
        t_words      words;
        logic [31:0] seed;
        logic        fold_en;
        logic [7:0]  held;
    } t_snapshot;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [5:0] back;
        back = 6'd32 - {1'b0, r};
        return (x << r) | (x >> back);
    endfunction

endpackage

FILE: hdl/string_hash_three_word_mix_unit.sv
// Top level of the 32-bit string hash unit with three running sums and a final mix.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | into unit | i_in_valid / o_in_stall   | i_data_byte, i_has_byte, i_last
//  out     | from unit | o_out_valid / i_out_stall | o_hash_value
//
// One request is taken in every clock cycle while o_in_stall is low; the single accumulator
// stage adds each byte into one of three 32-bit sums, so the rate is one byte per cycle.
// The hash of a string appears on o_out_valid once its last request has passed the capture
// stage, one seed stage and seven mix stages, none deeper than a three-input add; a stalled
// output holds the pipeline back.
// Reset is synchronous and active low; it clears the sums, block position, held byte and
// every valid flag, presets the length term and accepts requests in the first cycle after.
// o_in_stall rises only when all nine pipeline stages hold a hash and the output is stalled.
`timescale 1ns / 1ps
module string_hash_three_word_mix_unit
    import shtw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    // Captured sums, length term and held fifth byte of a finished string travel
    // together from the accumulator into the finishing pipeline.
    logic      snap_valid;
    logic      snap_ready;
    t_snapshot snap;

    // The accumulator takes a byte per request and, on a request marked last,
    // captures the state and starts afresh for the next string in the same cycle.
    shtw_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_last       (i_last),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // The finishing pipeline adds the seed, runs the mix steps one per stage and
    // holds its last stage as the output register while the output is stalled.
    shtw_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

FILE: hdl/shtw_accum.sv
// Byte accumulator: adds each byte into its sum and captures the sums at string end.
`timescale 1ns / 1ps
module shtw_accum
    import shtw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_last,
    output logic       o_snap_valid,
    input  logic       i_snap_ready,
    output t_snapshot  o_snap
);

    logic [31:0] r_sum_i, r_sum_j, r_sum_k, r_seed;
    logic [3:0]  r_pos;
    logic [7:0]  r_held;
    logic        r_snap_valid;
    t_snapshot   r_snap;

    logic [31:0] n_sum_i, n_sum_j, n_sum_k, n_seed;
    logic [3:0]  n_pos;
    logic [7:0]  n_held;
    logic [31:0] lane_val;
    logic        accept;

    assign o_in_stall   = r_snap_valid && !i_snap_ready;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    // Big-endian lane within the current 32-bit word of the block.
    assign lane_val = {24'd0, i_data_byte} << {~r_pos[1:0], 3'b000};

    always_comb begin
        n_sum_i = r_sum_i;
        n_sum_j = r_sum_j;
        n_sum_k = r_sum_k;
        n_seed  = r_seed;
        n_pos   = r_pos;
        n_held  = r_held;
        if (i_has_byte) begin
            if (r_pos < C_FIFTH_POS) begin
                n_sum_i = r_sum_i + lane_val;
            end else if (r_pos == C_FIFTH_POS) begin
                n_held = i_data_byte;
            end else if (r_pos < C_J_POS) begin
                n_sum_j = r_sum_j + lane_val;
            end else begin
                n_sum_k = r_sum_k + lane_val;
            end
            n_seed = r_seed + 32'd1;
            if (r_pos >= C_BLOCK_END) begin
                n_sum_j = r_sum_j + {r_held, 24'd0};
                n_held  = 8'd0;
                n_pos   = 4'd0;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_i      <= '0;
            r_sum_j      <= '0;
            r_sum_k      <= '0;
            r_seed       <= C_SEED_INIT;
            r_pos        <= '0;
            r_held       <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            // A new snapshot is only taken when the old one leaves or none is held.
            r_snap_valid <= (accept && i_last) || (r_snap_valid && !i_snap_ready);
            if (accept) begin
                if (i_last) begin
                    r_sum_i <= '0;
                    r_sum_j <= '0;
                    r_sum_k <= '0;
                    r_seed  <= C_SEED_INIT;
                    r_pos   <= '0;
                    r_held  <= '0;
                end else begin
                    r_sum_i <= n_sum_i;
                    r_sum_j <= n_sum_j;
                    r_sum_k <= n_sum_k;
                    r_seed  <= n_seed;
                    r_pos   <= n_pos;
                    r_held  <= n_held;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_snap.words.w0 <= n_sum_i;
            r_snap.words.w1 <= n_sum_j;
            r_snap.words.w2 <= n_sum_k;
            r_snap.seed     <= n_seed;
            r_snap.fold_en  <= (n_pos >= C_SPLIT_POS);
            r_snap.held     <= n_held;
        end
    end

endmodule

FILE: hdl/shtw_finish.sv
// Finishing pipeline: seed addition followed by the seven mix stages.
`timescale 1ns / 1ps
module shtw_finish
    import shtw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_valid,
    output logic        o_snap_ready,
    input  t_snapshot   i_snap,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    logic [C_STAGES-1:0] r_valid;
    t_words              r_words [C_STAGES];
    t_words              n_words [C_STAGES];
    logic [C_STAGES:0]   en;

    assign en[C_STAGES] = !i_out_stall;
    assign o_snap_ready = en[0];
    assign o_out_valid  = r_valid[C_STAGES-1];
    assign o_hash_value = r_words[C_STAGES-1].w1;

    always_comb begin
        n_words[0].w0 = i_snap.words.w0 + i_snap.seed
                      + (i_snap.fold_en ? {i_snap.held, 24'd0} : 32'd0);
        n_words[0].w1 = i_snap.words.w1 + i_snap.seed;
        n_words[0].w2 = i_snap.words.w2 + i_snap.seed;
    end

    genvar s;
    generate
        for (s = 0; s < C_STAGES; s++) begin : g_stage
            assign en[s] = !r_valid[s] || en[s+1];

            if (s > 0) begin : g_mix
                // The target word is rewritten and the roles rotate, so every
                // stage mixes its third word with its second.
                always_comb begin
                    n_words[s].w0 = r_words[s-1].w1;
                    n_words[s].w1 = (r_words[s-1].w2 ^ r_words[s-1].w1)
                                  - rotl32(r_words[s-1].w1, C_MIX_ROT[s-1]);
                    n_words[s].w2 = r_words[s-1].w0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (en[s]) begin
                    r_valid[s] <= (s == 0) ? i_snap_valid : r_valid[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[s]) begin
                    r_words[s] <= n_words[s];
                end
            end
        end
    endgenerate

endmodule

FILE: hdl/shtw_checker.sv
// Port checker for the string hash unit and its bind to the top level.
`timescale 1ns / 1ps
`include "string_hash_three_word_mix_unit_macros.svh"
module shtw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_hash_value
);

    `SHTW_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `SHTW_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_hash_value))
    `SHTW_ASSERT(a_stall_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    `SHTW_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind string_hash_three_word_mix_unit shtw_checker u_shtw_checker (.*);
